// ===== sv/ipv4lpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipv4lpm_pkg;

   localparam int MAX_IFACES = 4;
   localparam int IFACE_W    = $clog2(MAX_IFACES);
   localparam int CNT_W      = 3;
   localparam int ADDR_W     = 32;
   localparam int MTU_W      = 16;
   localparam int PLEN_W     = 6;

   // function codes of an input item
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // route kinds
   localparam logic KIND_DIRECT  = 1'b0;
   localparam logic KIND_GATEWAY = 1'b1;

   // stored interface entry as seen by the route comparator
   typedef struct packed {
      logic [ADDR_W-1:0] net;
      logic [ADDR_W-1:0] mask;
      logic [PLEN_W-1:0] plen;
      logic              valid;
   } entry_type;

   // best route so far, as needed by the comparator
   typedef struct packed {
      logic              have;
      logic [PLEN_W-1:0] len;
   } best_type;

   // number of one bits in one byte
   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int k = 0; k < 8; k++) begin
         n = n + {3'd0, v[k]};
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ipv4_longest_prefix_route_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none

// IPv4 longest-prefix route lookup over a table of four interfaces. A load
// item writes one interface entry; its prefix length is counted one mask
// byte per cycle. A lookup item scans N interfaces, where N is
// min(active_ifaces, 4): one route comparator visits one route per cycle,
// on-link then via for each interface, and separate steps take the item
// and hand the result to the output register. The input side stalls
// while an item is at work; a finished result waits in the output register
// without holding up the next item, but a lookup that finishes while the
// output register still holds a stalled result waits until that result
// leaves. csr_data may be written only while the block is idle; csr_ready is
// always high. An interface read before it was ever loaded is skipped.
module ipv4_longest_prefix_route_lookup (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration write channel
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [ipv4lpm_pkg::CNT_W-1:0]       csr_data,
   // request channel
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_func,
   input  wire logic [ipv4lpm_pkg::IFACE_W-1:0]     req_iface_index,
   input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]      req_iface_addr,
   input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]      req_iface_mask,
   input  wire logic [ipv4lpm_pkg::MTU_W-1:0]       req_iface_mtu,
   input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]      req_dest_addr,
   // response channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_found,
   output      logic                                rsp_route_type,
   output      logic [ipv4lpm_pkg::IFACE_W-1:0]     rsp_out_iface,
   output      logic [ipv4lpm_pkg::ADDR_W-1:0]      rsp_next_hop,
   output      logic [ipv4lpm_pkg::MTU_W-1:0]       rsp_route_mtu,
   output      logic [ipv4lpm_pkg::PLEN_W-1:0]      rsp_match_len
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   localparam int AW = ipv4lpm_pkg::ADDR_W;
   localparam int MW = ipv4lpm_pkg::MTU_W;
   localparam int PW = ipv4lpm_pkg::PLEN_W;
   localparam int IW = ipv4lpm_pkg::IFACE_W;
   localparam int CW = ipv4lpm_pkg::CNT_W;
   localparam int NI = ipv4lpm_pkg::MAX_IFACES;

   // interface table
   logic [AW-1:0] net_store  [NI];
   logic [AW-1:0] mask_store [NI];
   logic [PW-1:0] plen_store [NI];
   logic [MW-1:0] mtu_store  [NI];
   logic [NI-1:0] entry_valid_ff, entry_valid_in;

   state_type     state_ff, state_in;
   logic [CW-1:0] active_ff, active_in;
   logic [AW-1:0] dest_ff, dest_in;
   logic [IW-1:0] scan_if_ff, scan_if_in;
   logic          scan_via_ff, scan_via_in;
   logic [IW-1:0] last_if_ff, last_if_in;
   logic          have_ff, have_in;
   logic [PW-1:0] best_len_ff, best_len_in;
   logic          best_kind_ff, best_kind_in;
   logic [IW-1:0] best_if_ff, best_if_in;
   logic [AW-1:0] best_hop_ff, best_hop_in;
   logic [MW-1:0] best_mtu_ff, best_mtu_in;
   logic [IW-1:0] ld_idx_ff, ld_idx_in;
   logic [23:0]   ld_mask_ff, ld_mask_in;
   logic [1:0]    ld_cnt_ff, ld_cnt_in;
   logic [PW-1:0] ld_acc_ff, ld_acc_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          rsp_found_ff, rsp_kind_ff;
   logic [IW-1:0] rsp_iface_ff;
   logic [AW-1:0] rsp_hop_ff;
   logic [MW-1:0] rsp_mtu_ff;
   logic [PW-1:0] rsp_len_ff;

   logic          req_xfer;
   logic          rsp_xfer;
   logic          rsp_load;
   logic          tbl_wr;
   logic          plen_wr;
   logic [PW-1:0] plen_total;
   logic [CW-1:0] count;
   logic          take;
   ipv4lpm_pkg::entry_type scan_entry;
   ipv4lpm_pkg::best_type  best_now;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // clamp interface count to table size
   assign count = (active_ff > CW'(NI)) ? CW'(NI) : active_ff;

   // entry under scan
   assign scan_entry.net   = net_store[scan_if_ff];
   assign scan_entry.mask  = mask_store[scan_if_ff];
   assign scan_entry.plen  = plen_store[scan_if_ff];
   assign scan_entry.valid = entry_valid_ff[scan_if_ff];
   assign best_now.have    = have_ff;
   assign best_now.len     = best_len_ff;

   ipv4lpm_route_cmp u_cmp (
      .dest       (dest_ff),
      .entry      (scan_entry),
      .route_kind (scan_via_ff),
      .best       (best_now),
      .take       (take)
   );

   // table writes: entry fields at load transfer, prefix length at the end
   assign tbl_wr     = req_xfer && (req_func == ipv4lpm_pkg::FUNC_LOAD);
   assign plen_wr    = (state_ff == ST_LOAD) && (ld_cnt_ff == 2'd2);
   assign plen_total = ld_acc_ff + PW'(ipv4lpm_pkg::pop8(ld_mask_ff[7:0]));

   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         net_store[req_iface_index]  <= req_iface_addr & req_iface_mask;
         mask_store[req_iface_index] <= req_iface_mask;
         mtu_store[req_iface_index]  <= req_iface_mtu;
      end
      if (plen_wr) begin
         plen_store[ld_idx_ff] <= plen_total;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      dest_in        = dest_ff;
      scan_if_in     = scan_if_ff;
      scan_via_in    = scan_via_ff;
      last_if_in     = last_if_ff;
      have_in        = have_ff;
      best_len_in    = best_len_ff;
      best_kind_in   = best_kind_ff;
      best_if_in     = best_if_ff;
      best_hop_in    = best_hop_ff;
      best_mtu_in    = best_mtu_ff;
      ld_idx_in      = ld_idx_ff;
      ld_mask_in     = ld_mask_ff;
      ld_cnt_in      = ld_cnt_ff;
      ld_acc_in      = ld_acc_ff;
      entry_valid_in = entry_valid_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (csr_valid && csr_ready) begin
         active_in = csr_data;
      end

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_func == ipv4lpm_pkg::FUNC_LOAD) begin
                  // first mask byte counted now, the other three in load
                  ld_idx_in  = req_iface_index;
                  ld_mask_in = req_iface_mask[31:8];
                  ld_acc_in  = PW'(ipv4lpm_pkg::pop8(req_iface_mask[7:0]));
                  ld_cnt_in  = 2'd0;
                  entry_valid_in[req_iface_index] = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  dest_in      = req_dest_addr;
                  scan_if_in   = '0;
                  scan_via_in  = ipv4lpm_pkg::KIND_DIRECT;
                  last_if_in   = IW'(count - CW'(1));
                  have_in      = 1'b0;
                  best_len_in  = '0;
                  best_kind_in = ipv4lpm_pkg::KIND_DIRECT;
                  best_if_in   = '0;
                  best_hop_in  = '0;
                  best_mtu_in  = '0;
                  state_in     = (count == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_LOAD: begin
            ld_acc_in  = plen_total;
            ld_mask_in = {8'd0, ld_mask_ff[23:8]};
            ld_cnt_in  = ld_cnt_ff + 2'd1;
            if (plen_wr) begin
               entry_valid_in[ld_idx_ff] = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // one route per cycle through the shared comparator
            if (take) begin
               have_in      = 1'b1;
               best_kind_in = scan_via_ff;
               best_if_in   = scan_if_ff;
               best_mtu_in  = mtu_store[scan_if_ff];
               if (scan_via_ff == ipv4lpm_pkg::KIND_GATEWAY) begin
                  best_len_in = '0;
                  best_hop_in = scan_entry.net | AW'(1);
               end else begin
                  best_len_in = scan_entry.plen;
                  best_hop_in = '0;
               end
            end
            if (scan_via_ff == ipv4lpm_pkg::KIND_GATEWAY) begin
               scan_via_in = ipv4lpm_pkg::KIND_DIRECT;
               if (scan_if_ff == last_if_ff) begin
                  state_in = ST_DONE;
               end else begin
                  scan_if_in = scan_if_ff + IW'(1);
               end
            end else begin
               scan_via_in = ipv4lpm_pkg::KIND_GATEWAY;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_ff      <= '0;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         ld_cnt_ff      <= '0;
         scan_if_ff     <= '0;
         scan_via_ff    <= ipv4lpm_pkg::KIND_DIRECT;
      end else begin
         state_ff       <= state_in;
         active_ff      <= active_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         ld_cnt_ff      <= ld_cnt_in;
         scan_if_ff     <= scan_if_in;
         scan_via_ff    <= scan_via_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dest_ff      <= dest_in;
      last_if_ff   <= last_if_in;
      have_ff      <= have_in;
      best_len_ff  <= best_len_in;
      best_kind_ff <= best_kind_in;
      best_if_ff   <= best_if_in;
      best_hop_ff  <= best_hop_in;
      best_mtu_ff  <= best_mtu_in;
      ld_idx_ff    <= ld_idx_in;
      ld_mask_ff   <= ld_mask_in;
      ld_acc_ff    <= ld_acc_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= have_ff;
         rsp_kind_ff  <= best_kind_ff;
         rsp_iface_ff <= best_if_ff;
         rsp_hop_ff   <= best_hop_ff;
         rsp_mtu_ff   <= best_mtu_ff;
         rsp_len_ff   <= best_len_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_route_type = rsp_kind_ff;
   assign rsp_out_iface  = rsp_iface_ff;
   assign rsp_next_hop   = rsp_hop_ff;
   assign rsp_route_mtu  = rsp_mtu_ff;
   assign rsp_match_len  = rsp_len_ff;

   // a new result appears only from the done step
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done step");

   // a miss carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_route_type == 1'b0 && rsp_next_hop == '0 && rsp_route_mtu == '0 &&
          rsp_match_len == '0 && rsp_out_iface == '0))
      else $error("miss with nonzero fields");

   // a via route has prefix length zero and an odd gateway
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found && rsp_route_type == ipv4lpm_pkg::KIND_GATEWAY) |->
         (rsp_match_len == '0 && rsp_next_hop[0]))
      else $error("via route with bad length or gateway");

   // an interface entry is marked valid only at the end of its load
   assert property (@(posedge clock) disable iff (reset)
      $rose(entry_valid_ff[ld_idx_ff]) |-> $past(state_ff == ST_LOAD))
      else $error("entry marked valid outside load");

endmodule

`default_nettype wire

// ===== sv/ipv4lpm_route_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shared route comparator: decides whether the route under scan replaces the best one
module ipv4lpm_route_cmp (
   input  wire logic [ipv4lpm_pkg::ADDR_W-1:0] dest,
   input  wire ipv4lpm_pkg::entry_type         entry,
   input  wire logic                           route_kind,
   input  wire ipv4lpm_pkg::best_type          best,
   output      logic                           take
);

   logic subnet_hit;
   logic longer;

   // subnet match and strictly longer prefix
   assign subnet_hit = ((dest & entry.mask) == entry.net);
   assign longer     = !best.have || (entry.plen > best.len);

   // via route has prefix length zero, so it wins only over nothing
   always_comb begin
      take = 1'b0;
      if (entry.valid) begin
         if (route_kind == ipv4lpm_pkg::KIND_GATEWAY) begin
            take = !best.have;
         end else begin
            take = subnet_hit && longer;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int MAX_IFACES = ipv4lpm_pkg::MAX_IFACES;
   localparam int IFACE_W    = ipv4lpm_pkg::IFACE_W;
   localparam int CNT_W      = ipv4lpm_pkg::CNT_W;
   localparam int ADDR_W     = ipv4lpm_pkg::ADDR_W;
   localparam int MTU_W      = ipv4lpm_pkg::MTU_W;
   localparam int PLEN_W     = ipv4lpm_pkg::PLEN_W;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASE_ITEMS    = 130;

   // one route lookup result as the response port carries it
   typedef struct packed {
      logic              found;
      logic              route_type;
      logic [IFACE_W-1:0] out_iface;
      logic [ADDR_W-1:0] next_hop;
      logic [MTU_W-1:0]  route_mtu;
      logic [PLEN_W-1:0] match_len;
   } route_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = ipv4lpm_pkg::FUNC_LOAD;
   logic [IFACE_W-1:0]  req_iface_index = '0;
   logic [ADDR_W-1:0]   req_iface_addr = '0;
   logic [ADDR_W-1:0]   req_iface_mask = '0;
   logic [MTU_W-1:0]    req_iface_mtu = '0;
   logic [ADDR_W-1:0]   req_dest_addr = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic                rsp_route_type;
   logic [IFACE_W-1:0]  rsp_out_iface;
   logic [ADDR_W-1:0]   rsp_next_hop;
   logic [MTU_W-1:0]    rsp_route_mtu;
   logic [PLEN_W-1:0]   rsp_match_len;

   // shadow interface table and route count
   logic [ADDR_W-1:0]   tbl_net   [MAX_IFACES];
   logic [ADDR_W-1:0]   tbl_mask  [MAX_IFACES];
   logic [PLEN_W-1:0]   tbl_plen  [MAX_IFACES];
   logic [MTU_W-1:0]    tbl_mtu   [MAX_IFACES];
   bit                  tbl_valid [MAX_IFACES] = '{default: 1'b0};
   logic [CNT_W-1:0]    tbl_active = '0;

   route_result_type    route_expect_q [$];
   int                  fail_count = 0;
   int                  idle_pct = 0;
   int                  stall_left = 0;
   int                  quiet_cycles = 0;
   logic [ADDR_W-1:0]   route_base = '0;

   ipv4_longest_prefix_route_lookup dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_iface_index (req_iface_index),
      .req_iface_addr  (req_iface_addr),
      .req_iface_mask  (req_iface_mask),
      .req_iface_mtu   (req_iface_mtu),
      .req_dest_addr   (req_dest_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_route_type  (rsp_route_type),
      .rsp_out_iface   (rsp_out_iface),
      .rsp_next_hop    (rsp_next_hop),
      .rsp_route_mtu   (rsp_route_mtu),
      .rsp_match_len   (rsp_match_len)
   );

   // clock
   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // longest prefix over onlink/via routes of the active interfaces
   function automatic route_result_type predict_route(input logic [ADDR_W-1:0] dest);
      route_result_type r;
      int               best_len;
      int               best_if;
      int               n;
      logic             best_kind;
      r = '0;
      best_len = -1;
      best_if = 0;
      best_kind = ipv4lpm_pkg::KIND_DIRECT;
      n = (tbl_active > MAX_IFACES) ? MAX_IFACES : int'(tbl_active);
      for (int i = 0; i < n; i++) begin
         if (tbl_valid[i]) begin
            if ((dest & tbl_mask[i]) == tbl_net[i] && int'(tbl_plen[i]) > best_len) begin
               best_len = int'(tbl_plen[i]);
               best_if = i;
               best_kind = ipv4lpm_pkg::KIND_DIRECT;
            end
            if (best_len < 0) begin
               best_len = 0;
               best_if = i;
               best_kind = ipv4lpm_pkg::KIND_GATEWAY;
            end
         end
      end
      if (best_len >= 0) begin
         r.found = 1'b1;
         r.route_type = best_kind;
         r.out_iface = best_if[IFACE_W-1:0];
         r.next_hop = (best_kind == ipv4lpm_pkg::KIND_GATEWAY) ? (tbl_net[best_if] | 32'd1)
                                                              : '0;
         r.route_mtu = tbl_mtu[best_if];
         r.match_len = (best_kind == ipv4lpm_pkg::KIND_GATEWAY) ? '0 : tbl_plen[best_if];
      end
      return r;
   endfunction

   // send one request and track the table on its transfer
   task automatic send_item(input logic func, input logic [IFACE_W-1:0] idx,
                            input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] mask,
                            input logic [MTU_W-1:0] mtu, input logic [ADDR_W-1:0] dest);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_iface_index <= idx;
      req_iface_addr <= addr;
      req_iface_mask <= mask;
      req_iface_mtu <= mtu;
      req_dest_addr <= dest;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (func == ipv4lpm_pkg::FUNC_LOAD) begin
         tbl_net[idx] = addr & mask;
         tbl_mask[idx] = mask;
         tbl_plen[idx] = PLEN_W'($countones(mask));
         tbl_mtu[idx] = mtu;
         tbl_valid[idx] = 1'b1;
      end else begin
         route_expect_q.push_back(predict_route(dest));
      end
   endtask

   task automatic send_load(input logic [IFACE_W-1:0] idx, input logic [ADDR_W-1:0] addr,
                            input logic [ADDR_W-1:0] mask, input logic [MTU_W-1:0] mtu);
      send_item(ipv4lpm_pkg::FUNC_LOAD, idx, addr, mask, mtu, $urandom);
   endtask

   task automatic send_lookup(input logic [ADDR_W-1:0] dest);
      send_item(ipv4lpm_pkg::FUNC_LOOKUP, IFACE_W'($urandom), $urandom, $urandom,
                MTU_W'($urandom), dest);
   endtask

   // hold requests until all results are back and the last load has settled
   task automatic wait_table_idle();
      req_valid <= 1'b0;
      while (route_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_active_ifaces(input logic [CNT_W-1:0] count);
      wait_table_idle();
      csr_valid <= 1'b1;
      csr_data <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tbl_active = count;
   endtask

   // random load with mostly contiguous, overlapping subnets
   task automatic send_random_load();
      int                plen;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] addr;
      plen = $urandom_range(0, ADDR_W);
      mask = ($urandom_range(99) < 80) ? (32'hFFFF_FFFF << (ADDR_W - plen)) : $urandom;
      addr = ($urandom_range(99) < 70) ? (route_base ^ ($urandom >> $urandom_range(0, 31)))
                                       : $urandom;
      send_load(IFACE_W'($urandom), addr, mask, MTU_W'($urandom));
   endtask

   // random lookup, mostly aimed inside a loaded subnet
   task automatic send_random_lookup();
      int                pick;
      logic [ADDR_W-1:0] dest;
      pick = $urandom_range(0, MAX_IFACES - 1);
      if ($urandom_range(99) < 70 && tbl_valid[pick]) begin
         dest = tbl_net[pick] | ($urandom & ~tbl_mask[pick]);
      end else if ($urandom_range(99) < 50) begin
         dest = route_base ^ ($urandom >> $urandom_range(0, 31));
      end else begin
         dest = $urandom;
      end
      send_lookup(dest);
   endtask

   // lookups with no table: at reset, and with no interface loaded
   task automatic test_no_table();
      send_lookup(32'h0000_0000);
      send_lookup(32'hFFFF_FFFF);
      set_active_ifaces(3'd4);
      send_lookup(32'hC0A8_0101);
   endtask

   // hand-picked routes: extremes, skipped entries, ties, odd masks, counts
   task automatic test_directed_routes();
      send_load(2'd0, 32'hC0A8_0105, 32'hFFFF_FF00, 16'd1500);
      send_lookup(32'hC0A8_01FE);
      send_lookup(32'h0808_0808);
      send_load(2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_lookup(32'hFFFF_FFFF);
      send_load(2'd2, 32'h0000_0000, 32'h0000_0000, 16'h0000);
      send_lookup(32'h0000_0000);
      // non-contiguous mask
      send_load(2'd3, 32'h0A0F_0000, 32'hFF0F_0F00, 16'd9000);
      send_lookup(32'h0A0F_00AA);
      send_lookup(32'h0A1F_0000);
      // equal prefixes: the first interface wins
      send_load(2'd2, 32'hC0A8_0177, 32'hFFFF_FF00, 16'd1400);
      send_lookup(32'hC0A8_0133);
      set_active_ifaces(3'd1);
      send_lookup(32'hFFFF_FFFF);
      // count above the table size scans the whole table
      set_active_ifaces(3'd7);
      send_lookup(32'hFFFF_FFFF);
      send_lookup(32'h0A0F_0F00);
      set_active_ifaces(3'd0);
      send_lookup(32'hC0A8_0101);
   endtask

   // random phases over several route counts
   task automatic test_random_routes();
      logic [CNT_W-1:0] counts [10];
      counts = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd7, 3'd5, 3'd6, 3'd0, 3'd4, CNT_W'($urandom)};
      for (int p = 0; p < 10; p++) begin
         set_active_ifaces(counts[p]);
         route_base = $urandom;
         idle_pct = (p == 9) ? 0 : ((p % 3 == 1) ? 0 : 30);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == PHASE_ITEMS / 2) begin
               wait_table_idle();
            end
            if ($urandom_range(99) < 25) begin
               send_random_load();
            end else begin
               send_random_lookup();
            end
         end
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
         fail_count++;
      end
   endtask

   // result check and response stall bursts
   always @(posedge clock) begin
      route_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (route_expect_q.size() == 0) begin
            $error("route result transfer with no lookup pending");
            fail_count++;
         end else begin
            exp_r = route_expect_q.pop_front();
            check_field("found", 32'(exp_r.found), 32'(rsp_found));
            check_field("route_type", 32'(exp_r.route_type), 32'(rsp_route_type));
            check_field("out_iface", 32'(exp_r.out_iface), 32'(rsp_out_iface));
            check_field("next_hop", exp_r.next_hop, rsp_next_hop);
            check_field("route_mtu", 32'(exp_r.route_mtu), 32'(rsp_route_mtu));
            check_field("match_len", 32'(exp_r.match_len), 32'(rsp_match_len));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         stall_left = $urandom_range(1, 10);
      end
      rsp_stall <= (stall_left > 0);
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ipv4_longest_prefix_route_lookup regression: fail");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_no_table();
      test_directed_routes();
      test_random_routes();
      req_valid <= 1'b0;
      while (route_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ipv4_longest_prefix_route_lookup regression: pass");
      end else begin
         $display("ipv4_longest_prefix_route_lookup regression: fail");
      end
      $finish;
   end

endmodule
